// File: src/cli_pkg.sv
// Shared types, constants and helpers for the Coleman-Liau readability grader.
// Used by every module of the block; depends on nothing else.
package cli_pkg;

   // Width of the letter, mark and word-start counters (legal range 8 to 24).
   localparam int COUNT_WIDTH = 16;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // Reported count fields are 16 bits; a wider count is reported masked.
   localparam int FIELD_WIDTH = 16;
   localparam int EXT_WIDTH = (COUNT_WIDTH > FIELD_WIDTH) ? COUNT_WIDTH : FIELD_WIDTH;

   // Depth of the queue between the counting front and the grading back.
   // It must be a power of two so that the pointers wrap on their own.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Scaled products: 1176*L - (5920*S + 3060*W) equals 2*num + den of the
   // grade formula, and 200*W equals 2*den. The largest factor sum fits in
   // 14 bits, so this width never overflows.
   localparam int PROD_WIDTH = COUNT_WIDTH + 14;
   localparam int SCALE_LETTERS = 1176;
   localparam int SCALE_MARKS = 5920;
   localparam int SCALE_WORDS = 3060;
   localparam int SCALE_DEN = 200;

   // Grade limits.
   localparam int GRADE_WIDTH = 6;
   localparam int QUOT_WIDTH = 5;
   localparam logic [QUOT_WIDTH-1:0] QUOT_CAP = 5'd17;
   localparam logic signed [GRADE_WIDTH-1:0] GRADE_LOW = -6'sd1;

   // Character codes.
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_RETURN = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PERIOD = 8'h2E;
   localparam logic [7:0] CHAR_BANG = 8'h21;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // One request: a text byte and its end marker.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_payload_type;

   // One response: the grade and the three counts.
   typedef struct packed {
      logic signed [GRADE_WIDTH-1:0] grade;
      logic [FIELD_WIDTH-1:0]        letter_count;
      logic [FIELD_WIDTH-1:0]        word_count;
      logic [FIELD_WIDTH-1:0]        sentence_count;
   } rsp_payload_type;

   // Final counts of one text, handed from the front to the back.
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] letters;
      logic [COUNT_WIDTH-1:0] words;
      logic [COUNT_WIDTH-1:0] marks;
   } cli_counts_type;

   // Saturating increment of a count.
   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   // Low 16 bits of a count, zero extended when the count is narrower.
   function automatic logic [FIELD_WIDTH-1:0] to_field(input logic [COUNT_WIDTH-1:0] v);
      logic [EXT_WIDTH-1:0] ext;
      ext = EXT_WIDTH'(v);
      return ext[FIELD_WIDTH-1:0];
   endfunction

endpackage

// File: src/text_readability_grader.sv
// Top level of the Coleman-Liau readability grader: counting front, totals
// queue and grading back end. Depends on cli_pkg, cli_front, cli_queue, cli_back.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_payload (text byte, end mark)
//   rsp_      out        rsp_valid / rsp_stall  rsp_payload (grade, three counts)
//
// The front takes one request per cycle while req_stall is low; only the last byte of a text yields a response.
// Grading a text steps the back end through scale, offset, a subtract loop (up to 17) and done.
// Two finished texts can wait in the queue, so the front keeps counting during grading.
// req_stall rises only while that queue is full. Synchronous reset clears the running counts and the queue.
module text_readability_grader import cli_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic           q_push, q_full, q_pop, q_not_empty;
   cli_counts_type q_push_data, q_pop_data;

   // Byte counting.
   cli_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_push_data)
   );

   // Totals of finished texts.
   cli_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_pop_data)
   );

   // Grade computation and response.
   cli_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (q_pop_data),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: src/cli_front.sv
// Counting front of the readability grader: classifies each text byte and
// keeps the running counts. Depends on cli_pkg.
module cli_front import cli_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            q_full,
   output logic            q_push,
   output cli_counts_type  q_data
);

   logic [COUNT_WIDTH-1:0] letters_ff, letters_in;
   logic [COUNT_WIDTH-1:0] starts_ff, starts_in;
   logic [COUNT_WIDTH-1:0] marks_ff, marks_in;
   logic                   prev_space_ff, prev_space_in;

   logic [COUNT_WIDTH-1:0] letters_next, starts_next, marks_next;
   logic                   is_letter, is_space, is_mark, accept;
   logic [7:0]             c;

   // Requests wait only while the queue has no room.
   assign req_stall = q_full;
   assign accept = req_valid && !req_stall;
   assign c = req_payload.text_byte;

   // Byte classification.
   always_comb begin
      is_letter = ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z))
               || ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
      is_space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_RETURN));
      is_mark = (c == CHAR_PERIOD) || (c == CHAR_BANG)
             || (c == CHAR_QUESTION) || (c == CHAR_COLON);
   end

   // Counts including the current byte.
   always_comb begin
      letters_next = is_letter ? sat_inc(letters_ff) : letters_ff;
      starts_next = (is_letter && prev_space_ff) ? sat_inc(starts_ff) : starts_ff;
      marks_next = is_mark ? sat_inc(marks_ff) : marks_ff;
   end

   // On the last byte the totals go to the queue and the counts clear.
   always_comb begin
      q_push = accept && req_payload.end_of_text;
      q_data.letters = letters_next;
      q_data.words = sat_inc(starts_next);
      q_data.marks = marks_next;
      letters_in = letters_ff;
      starts_in = starts_ff;
      marks_in = marks_ff;
      prev_space_in = prev_space_ff;
      if (accept) begin
         if (req_payload.end_of_text) begin
            letters_in = '0;
            starts_in = '0;
            marks_in = '0;
            prev_space_in = 1'b0;
         end else begin
            letters_in = letters_next;
            starts_in = starts_next;
            marks_in = marks_next;
            prev_space_in = is_space;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         letters_ff <= '0;
         starts_ff <= '0;
         marks_ff <= '0;
         prev_space_ff <= 1'b0;
      end else begin
         letters_ff <= letters_in;
         starts_ff <= starts_in;
         marks_ff <= marks_in;
         prev_space_ff <= prev_space_in;
      end
   end

   // A finished text leaves the counters clear for the next one.
   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      q_push |=> (letters_ff == '0) && (starts_ff == '0) && (marks_ff == '0)
                 && !prev_space_ff)
      else $error("counts not cleared after end of text");

endmodule

// File: src/cli_queue.sv
// Short queue of per-text count totals between the front and the back.
// Depends on cli_pkg.
module cli_queue import cli_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  cli_counts_type push_data,
   output logic           full,
   input  logic           pop,
   output logic           not_empty,
   output cli_counts_type pop_data
);

   cli_counts_type          store_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;
   logic [QPTR_WIDTH-1:0]   ptr_gap;

   assign full = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data = store_ff[rd_ptr_ff];

   // Pointer distance, wrapped at the pointer width.
   assign ptr_gap = wr_ptr_ff - rd_ptr_ff;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The fill count matches the pointer distance; empty and full are exempt, since both give a zero distance.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) || (count_ff == QCNT_WIDTH'(QUEUE_DEPTH))
      || (QCNT_WIDTH'(ptr_gap) == count_ff))
      else $error("queue fill count out of step with pointers");

endmodule

// File: src/cli_back.sv
// Grading back end: scales the totals of one text, divides by repeated
// subtraction and holds the response. Depends on cli_pkg.
module cli_back import cli_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_not_empty,
   input  cli_counts_type  q_data,
   output logic            q_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCALE  = 5'b00010,
      ST_OFFSET = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_DONE   = 5'b10000
   } back_state_type;

   back_state_type          state_ff, state_in;
   cli_counts_type          counts_ff;
   logic [PROD_WIDTH-1:0]   pos_ff, neg_ff, den_ff, rem_ff;
   logic [QUOT_WIDTH-1:0]   quot_ff, quot_in;
   logic signed [GRADE_WIDTH-1:0] grade_ff;
   logic                    step_ok;

   assign q_pop = (state_ff == ST_IDLE) && q_not_empty;
   assign step_ok = (rem_ff >= den_ff) && (quot_ff != QUOT_CAP);
   assign rsp_valid = (state_ff == ST_DONE);

   // Sequencer: take totals, scale, offset, divide, then hold the response.
   always_comb begin
      state_in = state_ff;
      quot_in = quot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_OFFSET;
         end
         ST_OFFSET: begin
            quot_in = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (step_ok) begin
               quot_in = quot_ff + 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         quot_ff <= '0;
      end else begin
         state_ff <= state_in;
         quot_ff <= quot_in;
      end
   end

   // Datapath: constant products, then one subtract per cycle.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         counts_ff <= q_data;
      end
      if (state_ff == ST_SCALE) begin
         pos_ff <= PROD_WIDTH'(counts_ff.letters) * PROD_WIDTH'(SCALE_LETTERS);
         neg_ff <= PROD_WIDTH'(counts_ff.marks) * PROD_WIDTH'(SCALE_MARKS)
                 + PROD_WIDTH'(counts_ff.words) * PROD_WIDTH'(SCALE_WORDS);
         den_ff <= PROD_WIDTH'(counts_ff.words) * PROD_WIDTH'(SCALE_DEN);
      end
      // A negative rounded numerator can only give the low grade; zero works.
      if (state_ff == ST_OFFSET) begin
         rem_ff <= (pos_ff >= neg_ff) ? pos_ff - neg_ff : '0;
      end
      if ((state_ff == ST_DIVIDE) && step_ok) begin
         rem_ff <= rem_ff - den_ff;
      end
      if ((state_ff == ST_DIVIDE) && !step_ok) begin
         grade_ff <= (quot_ff == '0) ? GRADE_LOW : GRADE_WIDTH'({1'b0, quot_ff});
      end
   end

   // Response fields.
   always_comb begin
      rsp_payload.grade = grade_ff;
      rsp_payload.letter_count = to_field(counts_ff.letters);
      rsp_payload.word_count = to_field(counts_ff.words);
      rsp_payload.sentence_count = to_field(counts_ff.marks);
   end

   // The quotient never runs past the top grade.
   a_quot_capped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (quot_ff <= QUOT_CAP))
      else $error("grade quotient exceeded its cap");

   // Totals are taken from the queue only while the back end is free.
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == ST_SCALE))
      else $error("queue popped outside the idle state");

endmodule

// File: verif/text_readability_grader_tb.sv
// Self-checking testbench for text_readability_grader: directed and random texts
// with random request gaps and random response stalls, checked against a built-in grader.
// Depends on cli_pkg and the text_readability_grader RTL.
module text_readability_grader_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cli_pkg::*;

   // Largest value that a saturating count can hold.
   localparam longint COUNT_LIMIT = (64'd1 << COUNT_WIDTH) - 1;
   localparam int GRADE_FLOOR = -1;
   localparam int GRADE_CEILING = 17;
   localparam int RANDOM_BYTES = 420;
   localparam int RANDOM_TEXTS = 30;

   // One queued request byte; quiet bytes are sent back to back.
   typedef struct packed {
      req_payload_type payload;
      logic            quiet;
   } queued_byte_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   queued_byte_type pending_text[$];
   logic [7:0]      text_buf[$];
   rsp_payload_type expected_grades[$];
   int              texts_queued = 0;
   int              responses_seen = 0;
   int              mismatch_count = 0;

   // Running counts of the text whose bytes are being accepted.
   longint letter_total = 0;
   longint word_start_total = 0;
   longint mark_total = 0;
   bit     after_whitespace = 1'b0;

   logic req_taken = 1'b0;
   int   req_gap = 0;
   bit   req_burst = 1'b0;
   int   rsp_hold = 0;

   text_readability_grader DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #6 clock = ~clock;

   // Idle length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 2);
      if (roll < 97) return $urandom_range(3, 8);
      return $urandom_range(20, 50);
   endfunction

   function automatic longint bump(input longint count);
      return (count >= COUNT_LIMIT) ? COUNT_LIMIT : count + 1;
   endfunction

   // Coleman-Liau grade in exact integers, rounded half away from zero; under 1 is -1, over 16 is 17.
   function automatic logic signed [GRADE_WIDTH-1:0] coleman_liau_grade(
      input longint letters, input longint marks, input longint words);
      longint num;
      longint den;
      longint quot;
      num = 588 * letters - 2960 * marks - 1580 * words;
      den = 100 * words;
      if (num >= 0) begin
         quot = (2 * num + den) / (2 * den);
      end else begin
         quot = -((-2 * num + den) / (2 * den));
      end
      if (quot < 1) begin
         quot = GRADE_FLOOR;
      end else if (quot > 16) begin
         quot = GRADE_CEILING;
      end
      return quot[GRADE_WIDTH-1:0];
   endfunction

   // Count one accepted byte; the last byte of a text yields the expected response.
   task automatic count_text_byte(input req_payload_type request);
      logic [7:0]      c;
      rsp_payload_type result;
      longint          words;
      c = request.text_byte;
      if ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
          (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)) begin
         letter_total = bump(letter_total);
         if (after_whitespace) begin
            word_start_total = bump(word_start_total);
         end
      end
      if (c == CHAR_PERIOD || c == CHAR_BANG || c == CHAR_QUESTION || c == CHAR_COLON) begin
         mark_total = bump(mark_total);
      end
      after_whitespace = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_RETURN);
      if (request.end_of_text) begin
         words = bump(word_start_total);
         result.grade = coleman_liau_grade(letter_total, mark_total, words);
         result.letter_count = FIELD_WIDTH'(letter_total);
         result.word_count = FIELD_WIDTH'(words);
         result.sentence_count = FIELD_WIDTH'(mark_total);
         expected_grades.push_back(result);
         letter_total = 0;
         word_start_total = 0;
         mark_total = 0;
         after_whitespace = 1'b0;
      end
   endtask

   task automatic compare_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Text building helpers; close_text marks the last buffered byte as end of text.
   task automatic add_string(input string s);
      for (int i = 0; i < s.len(); i++) begin
         text_buf.push_back(s[i]);
      end
   endtask

   task automatic close_text(input bit quiet);
      queued_byte_type entry;
      while (text_buf.size() != 0) begin
         entry.payload.text_byte = text_buf.pop_front();
         entry.payload.end_of_text = (text_buf.size() == 0);
         entry.quiet = quiet;
         pending_text.push_back(entry);
      end
      texts_queued++;
   endtask

   function automatic logic [7:0] random_letter();
      if ($urandom_range(0, 1) == 0) return CHAR_UPPER_A + 8'($urandom_range(0, 25));
      return CHAR_LOWER_A + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_space();
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(CHAR_TAB, CHAR_RETURN));
      return CHAR_SPACE;
   endfunction

   function automatic logic [7:0] random_mark();
      case ($urandom_range(0, 3))
         0: return CHAR_PERIOD;
         1: return CHAR_BANG;
         2: return CHAR_QUESTION;
         default: return CHAR_COLON;
      endcase
   endfunction

   // Well-formed prose with random word lengths and mark density, a few stray bytes.
   task automatic add_prose();
      int words;
      int longest;
      int mark_odds;
      words = $urandom_range(1, 5);
      longest = $urandom_range(1, 12);
      mark_odds = $urandom_range(0, 60);
      if ($urandom_range(0, 4) == 0) text_buf.push_back(random_space());
      for (int w = 0; w < words; w++) begin
         if (w != 0) begin
            repeat ($urandom_range(1, 2)) text_buf.push_back(random_space());
         end
         repeat ($urandom_range(1, longest)) text_buf.push_back(random_letter());
         if ($urandom_range(0, 99) < mark_odds) text_buf.push_back(random_mark());
         if ($urandom_range(0, 19) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 5) == 0) text_buf.push_back(random_space());
   endtask

   // Request driver: holds a request until taken, then idles or sends the next byte.
   always @(negedge clock) begin : drive_requests
      queued_byte_type entry;
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // Request still waiting on a stall; keep it steady.
         end else if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_text.size() != 0) begin
            entry = pending_text.pop_front();
            req_payload <= entry.payload;
            req_valid <= 1'b1;
            if ($urandom_range(0, 63) == 0) req_burst = !req_burst;
            req_gap = (entry.quiet || req_burst) ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall: stall stretches alternate with open stretches, some of them long.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         rsp_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 100)
                                                 : $urandom_range(0, 6);
      end else begin
         rsp_hold = pick_gap();
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold = rsp_hold - 1;
         end
      end
   end

   // Predict on each accepted request and check each accepted response.
   always @(posedge clock) begin : score
      rsp_payload_type want;
      if (!reset) begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) count_text_byte(req_payload);
         if (rsp_valid && !rsp_stall) begin
            responses_seen++;
            if (expected_grades.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual grade %0d letters %0d",
                        $time, $signed(rsp_payload.grade), rsp_payload.letter_count);
               mismatch_count++;
            end else begin
               want = expected_grades.pop_front();
               compare_field("grade", $signed(want.grade), $signed(rsp_payload.grade));
               compare_field("letter_count", want.letter_count, rsp_payload.letter_count);
               compare_field("word_count", want.word_count, rsp_payload.word_count);
               compare_field("sentence_count", want.sentence_count,
                             rsp_payload.sentence_count);
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin : run
      int base_bytes;
      int base_texts;

      // Non-letters around the letter ranges, high bytes, a zero byte, every mark but the period,
      // a word started after a return, and whitespace as the last byte.
      text_buf.push_back(8'h00);
      text_buf.push_back(8'hFF);
      text_buf.push_back(8'h80);
      add_string("@[`{");
      text_buf.push_back(CHAR_RETURN);
      add_string("b!?:");
      text_buf.push_back(8'h0B);
      text_buf.push_back(CHAR_SPACE);
      close_text(1'b0);

      // Starts with a letter right after a cleared whitespace flag; its unrounded grade is 13.5, rounded to 14.
      add_string("Zabcdefg\tAzyxwvu.");
      close_text(1'b1);

      // Random texts: mostly prose, the rest raw byte noise.
      base_bytes = pending_text.size();
      base_texts = texts_queued;
      while (pending_text.size() - base_bytes < RANDOM_BYTES ||
             texts_queued - base_texts < RANDOM_TEXTS) begin
         if ($urandom_range(0, 3) != 0) begin
            add_prose();
         end else begin
            repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
         end
         close_text(1'b0);
      end

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Every queued text must come back as one response.
      while (responses_seen < texts_queued) @(negedge clock);
      repeat (40) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Safety net against a hung handshake.
   initial begin
      #15_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
